/* rtl/core/pmc_pkg.sv */
`timescale 1ns / 1ps

package pmc_pkg;

  // Occupancy codes, shared by stable and wanted state
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_PRESENCE = 2'd1;
  localparam logic [1:0] ST_MOTION   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RAW_WANDER    = 3'd0;
  localparam logic [2:0] CFG_RAW_JITTER    = 3'd1;
  localparam logic [2:0] CFG_PRESENCE_GAIN = 3'd2;
  localparam logic [2:0] CFG_MOTION_GAIN   = 3'd3;
  localparam logic [2:0] CFG_PRESENCE_EXIT = 3'd4;
  localparam logic [2:0] CFG_MOTION_EXIT   = 3'd5;
  localparam logic [2:0] CFG_EMPTY_CONFIRM = 3'd6;
  localparam logic [2:0] CFG_ACTIVE_CONFIRM = 3'd7;

  // 0.05 in Q0.16 (raw thresholds at or below are used unscaled)
  localparam logic [15:0] RAW_KEEP_LIMIT    = 16'd3276;
  // 0.0001 in Q0.16 (wander at or below counts as zero)
  localparam logic [15:0] WANDER_ZERO_LIMIT = 16'd6;
  localparam logic [7:0]  COUNT_MAX         = 8'd255;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MENTER,
    PH_PEXIT,
    PH_MEXIT,
    PH_DECIDE
  } pmc_phase_t;

  typedef struct packed {
    logic [15:0] wander_sample;
    logic [15:0] jitter_sample;
  } pmc_sample_t;

  typedef struct packed {
    logic [1:0]  stable_state;
    logic [1:0]  wanted_state;
    logic [7:0]  confirm_count;
    logic [15:0] presence_level;
  } pmc_result_t;

  typedef struct packed {
    logic [15:0] p_enter;
    logic [15:0] m_enter;
    logic [15:0] p_exit;
    logic [15:0] m_exit;
  } pmc_thr_t;

endpackage

/* rtl/core/pmc_scale.sv */
`timescale 1ns / 1ps

// Shared Q0.16 x Q4.8 scaler, saturating at 65535, registered output.
module pmc_scale (
  input  logic        clk,
  input  logic [15:0] level,
  input  logic [11:0] gain,
  input  logic        bypass,
  output logic [15:0] product
);
  import pmc_pkg::*;

  logic [27:0] full;
  logic [15:0] scaled;

  always_comb begin
    full   = 28'(level) * 28'(gain);
    scaled = (full[27:24] != 4'd0) ? 16'hFFFF : full[23:8];
  end

  always_ff @(posedge clk) begin
    product <= bypass ? level : scaled;
  end

endmodule

/* rtl/core/pmc_classify.sv */
`timescale 1ns / 1ps

// Hysteresis decision and frame confirmation; state advances on step.
module pmc_classify #(
  parameter logic [15:0] JITTER_FALLBACK_MIN   = 16'd655,
  parameter logic [15:0] WANDER_FALLBACK_LEVEL = 16'd1311
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  pmc_pkg::pmc_sample_t sample,
  input  pmc_pkg::pmc_thr_t    thr,
  input  logic [7:0]           empty_frames,
  input  logic [7:0]           active_frames,
  output pmc_pkg::pmc_result_t result
);
  import pmc_pkg::*;

  logic [1:0]  current_state, current_state_next;
  logic [1:0]  candidate_state, candidate_state_next;
  logic [7:0]  candidate_count, candidate_count_next;
  logic [15:0] level;
  logic [1:0]  want;
  logic [7:0]  need;
  logic [7:0]  bumped;

  always_comb begin
    level = sample.wander_sample;
    if (sample.wander_sample <= WANDER_ZERO_LIMIT &&
        sample.jitter_sample >= JITTER_FALLBACK_MIN &&
        sample.jitter_sample < thr.m_enter) begin
      level = WANDER_FALLBACK_LEVEL;
    end

    case (current_state)
      ST_MOTION: begin
        if (sample.jitter_sample > thr.m_exit) want = ST_MOTION;
        else if (level > thr.p_enter || level > thr.p_exit) want = ST_PRESENCE;
        else want = ST_EMPTY;
      end
      ST_PRESENCE: begin
        if (sample.jitter_sample > thr.m_enter) want = ST_MOTION;
        else if (level > thr.p_exit) want = ST_PRESENCE;
        else want = ST_EMPTY;
      end
      default: begin
        if (sample.jitter_sample > thr.m_enter) want = ST_MOTION;
        else if (level > thr.p_enter) want = ST_PRESENCE;
        else want = ST_EMPTY;
      end
    endcase

    need   = (want == ST_EMPTY) ? empty_frames : active_frames;
    bumped = (candidate_count == COUNT_MAX) ? candidate_count : candidate_count + 8'd1;

    current_state_next   = current_state;
    candidate_state_next = candidate_state;
    candidate_count_next = candidate_count;
    if (want == current_state) begin
      candidate_state_next = current_state;
      candidate_count_next = 8'd0;
    end else begin
      if (want == candidate_state) begin
        candidate_count_next = bumped;
      end else begin
        candidate_state_next = want;
        candidate_count_next = 8'd1;
      end
      if (candidate_count_next >= need) begin
        current_state_next   = want;
        candidate_state_next = want;
        candidate_count_next = 8'd0;
      end
    end

    result.stable_state   = current_state_next;
    result.wanted_state   = want;
    result.confirm_count  = candidate_count_next;
    result.presence_level = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state   <= ST_EMPTY;
      candidate_state <= ST_EMPTY;
      candidate_count <= 8'd0;
    end else if (step) begin
      current_state   <= current_state_next;
      candidate_state <= candidate_state_next;
      candidate_count <= candidate_count_next;
    end
  end

endmodule

/* rtl/core/presence_motion_classifier.sv */
`timescale 1ns / 1ps

// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------
// sample   | sample_valid / sample_stall| pmc_sample_t (wander, jitter)
// result   | result_valid / result_stall| pmc_result_t (states, count, level)
// cfg      | cfg_write                  | cfg_index, cfg_data
//
// Each transaction steps through its phases in order: the accept, in which the
// shared scaler forms presence enter, then motion enter, presence exit and
// motion exit, then the decision. sample_stall is high from after the accept
// until the decision completes. The decision waits while a previous result is
// still held and stalled. Reset (rst, synchronous) restores register defaults,
// empties the state and drops result_valid.
module presence_motion_classifier #(
  parameter logic [15:0] JITTER_FALLBACK_MIN   = 16'd655,
  parameter logic [15:0] WANDER_FALLBACK_LEVEL = 16'd1311
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  pmc_pkg::pmc_sample_t sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pmc_pkg::pmc_result_t result,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import pmc_pkg::*;

  // configuration registers
  logic [15:0] raw_wander_threshold;
  logic [15:0] raw_jitter_threshold;
  logic [11:0] presence_gain;
  logic [11:0] motion_gain;
  logic [11:0] presence_exit_gain;
  logic [11:0] motion_exit_gain;
  logic [7:0]  empty_frames;
  logic [7:0]  active_frames;

  pmc_phase_t  phase, phase_next;
  pmc_sample_t held;
  logic [15:0] p_enter;
  logic [15:0] m_enter;
  logic [15:0] p_exit;
  logic [15:0] product;
  pmc_thr_t    thr;
  pmc_result_t decided;

  // sequencer outputs
  logic [15:0] op_level;
  logic [11:0] op_gain;
  logic        op_bypass;
  logic        load_p_enter;
  logic        load_m_enter;
  logic        load_p_exit;
  logic        step;

  logic take;

  assign take         = sample_valid && !sample_stall;
  assign sample_stall = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_wander_threshold <= 16'd0;
      raw_jitter_threshold <= 16'd0;
      presence_gain        <= 12'd256;
      motion_gain          <= 12'd256;
      presence_exit_gain   <= 12'd192;
      motion_exit_gain     <= 12'd192;
      empty_frames         <= 8'd10;
      active_frames        <= 8'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RAW_WANDER:     raw_wander_threshold <= cfg_data;
        CFG_RAW_JITTER:     raw_jitter_threshold <= cfg_data;
        CFG_PRESENCE_GAIN:  presence_gain        <= cfg_data[11:0];
        CFG_MOTION_GAIN:    motion_gain          <= cfg_data[11:0];
        CFG_PRESENCE_EXIT:  presence_exit_gain   <= cfg_data[11:0];
        CFG_MOTION_EXIT:    motion_exit_gain     <= cfg_data[11:0];
        CFG_EMPTY_CONFIRM:  empty_frames         <= cfg_data[7:0];
        CFG_ACTIVE_CONFIRM: active_frames        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:   if (take) phase_next = PH_MENTER;
      PH_MENTER: phase_next = PH_PEXIT;
      PH_PEXIT:  phase_next = PH_MEXIT;
      PH_MEXIT:  phase_next = PH_DECIDE;
      PH_DECIDE: if (!result_valid || !result_stall) phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  // scaler operands and loads; product is the registered result of the operands
  always_comb begin
    op_level     = raw_wander_threshold;
    op_gain      = presence_gain;
    op_bypass    = (raw_wander_threshold <= RAW_KEEP_LIMIT);
    load_p_enter = 1'b0;
    load_m_enter = 1'b0;
    load_p_exit  = 1'b0;
    step         = 1'b0;
    case (phase)
      PH_IDLE: ;  // presence enter computes while idle, ready at accept
      PH_MENTER: begin
        op_level     = raw_jitter_threshold;
        op_gain      = motion_gain;
        op_bypass    = (raw_jitter_threshold <= RAW_KEEP_LIMIT);
        load_p_enter = 1'b1;
      end
      PH_PEXIT: begin
        op_level     = p_enter;
        op_gain      = presence_exit_gain;
        op_bypass    = 1'b0;
        load_m_enter = 1'b1;
      end
      PH_MEXIT, PH_DECIDE: begin
        // decide keeps the motion exit operands so product stays put on a wait
        op_level    = m_enter;
        op_gain     = motion_exit_gain;
        op_bypass   = 1'b0;
        load_p_exit = (phase == PH_MEXIT);
        step        = (phase == PH_DECIDE) && (!result_valid || !result_stall);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= PH_IDLE;
    else     phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    if (take)         held    <= sample;
    if (load_p_enter) p_enter <= product;
    if (load_m_enter) m_enter <= product;
    if (load_p_exit)  p_exit  <= product;
  end

  pmc_scale u_scale (
    .clk     (clk),
    .level   (op_level),
    .gain    (op_gain),
    .bypass  (op_bypass),
    .product (product)
  );

  assign thr = '{p_enter: p_enter, m_enter: m_enter, p_exit: p_exit, m_exit: product};

  pmc_classify #(
    .JITTER_FALLBACK_MIN   (JITTER_FALLBACK_MIN),
    .WANDER_FALLBACK_LEVEL (WANDER_FALLBACK_LEVEL)
  ) u_classify (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .sample        (held),
    .thr           (thr),
    .empty_frames  (empty_frames),
    .active_frames (active_frames),
    .result        (decided)
  );

  // output register: holds a finished transaction while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) result <= decided;
  end

endmodule
